// ===== hdl/abp_pkg.sv =====
// abp_pkg: shared types and constants for the multi-radix palindrome checker
// no dependencies; imported by abp_div, any_base_palindrome_check_unit and the testbench
package abp_pkg;

    // quotient bits resolved per divider cycle
    localparam int STEP_BITS = 4;

    // smallest radix tried
    localparam int SMALLEST_BASE = 2;

    // width and reset value of the largest_base register
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] RESET_BASE = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV
    } seq_state_t;

endpackage

// ===== hdl/any_base_palindrome_check_unit.sv =====
// any_base_palindrome_check_unit: top level, radix sequencer around one shared divider
// depends on abp_pkg and abp_div
//
// Pulse start while busy is low to hand in number_value; busy stays high until the
// answer appears on is_palindrome_somewhere for one cycle, marked by done, which must
// be taken in that cycle. Radices from 2 up to the clamped largest_base are tried in
// turn; each digit costs one pass through the iterative divider and each radix one more
// pass through ST_CHECK. largest_base is to be written through cfg_valid/cfg_data only
// while idle; the user keeps to this, the block itself does not enforce it. cfg_ready is
// always high.
module any_base_palindrome_check_unit #(
    parameter int VALUE_WIDTH = 20,
    parameter int BASE_LIMIT  = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [VALUE_WIDTH-1:0]      number_value,
    output logic                        done,
    output logic                        is_palindrome_somewhere,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [abp_pkg::CFG_W-1:0]   cfg_data
);
    import abp_pkg::*;

    localparam int RADIX_W = $clog2(BASE_LIMIT + 1);
    localparam int REV_W   = VALUE_WIDTH + RADIX_W;

    seq_state_t             state_reg;
    seq_state_t             state_next;
    logic [CFG_W-1:0]       largest_base_reg;
    logic [RADIX_W-1:0]     top_reg;
    logic [RADIX_W-1:0]     top_next;
    logic [RADIX_W-1:0]     radix_reg;
    logic [RADIX_W-1:0]     radix_next;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic [VALUE_WIDTH-1:0] work_reg;
    logic [VALUE_WIDTH-1:0] work_next;
    logic [REV_W-1:0]       rev_reg;
    logic [REV_W-1:0]       rev_next;
    logic                   done_reg;
    logic                   done_next;
    logic                   result_reg;
    logic                   result_next;

    logic [RADIX_W-1:0]     top_clamp;
    logic [REV_W-1:0]       rev_acc;
    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [RADIX_W-1:0]     div_rem;

    abp_div #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .RADIX_W     (RADIX_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (work_reg),
        .divisor   (radix_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // clamp the configured radix into the supported range
    always_comb
    begin
        if (int'(largest_base_reg) < SMALLEST_BASE)
            top_clamp = RADIX_W'(SMALLEST_BASE);
        else if (int'(largest_base_reg) > BASE_LIMIT)
            top_clamp = RADIX_W'(BASE_LIMIT);
        else
            top_clamp = RADIX_W'(largest_base_reg);
    end

    // digit-reversed value, built one digit per divider pass
    assign rev_acc = REV_W'(rev_reg * REV_W'(radix_reg)) + REV_W'(div_rem);

    always_comb
    begin
        state_next  = state_reg;
        top_next    = top_reg;
        radix_next  = radix_reg;
        value_next  = value_reg;
        work_next   = work_reg;
        rev_next    = rev_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        div_start   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    value_next = number_value;
                    work_next  = number_value;
                    rev_next   = '0;
                    radix_next = RADIX_W'(SMALLEST_BASE);
                    top_next   = top_clamp;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (work_reg == '0)
                begin
                    if (rev_reg == REV_W'(value_reg))
                    begin
                        result_next = 1'b1;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else if (radix_reg == top_reg)
                    begin
                        result_next = 1'b0;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        radix_next = radix_reg + 1'b1;
                        work_next  = value_reg;
                        rev_next   = '0;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    work_next  = div_quo;
                    rev_next   = rev_acc;
                    state_next = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            done_reg         <= 1'b0;
            largest_base_reg <= RESET_BASE;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_valid)
                largest_base_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        radix_reg  <= radix_next;
        value_reg  <= value_next;
        work_reg   <= work_next;
        rev_reg    <= rev_next;
        result_reg <= result_next;
    end

    assign busy                    = (state_reg != ST_IDLE);
    assign done                    = done_reg;
    assign is_palindrome_somewhere = result_reg;
    assign cfg_ready               = 1'b1;

    // answer only follows an item in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without an item in progress");

    // one result beat per item
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

    // accepted item keeps the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start the sequencer");

    // radix stays within the clamped range while working
    a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (radix_reg >= RADIX_W'(SMALLEST_BASE)) && (radix_reg <= top_reg))
        else $error("radix out of range");

endmodule

// ===== hdl/abp_div.sv =====
// abp_div: multi-cycle restoring divider, STEP_BITS quotient bits per cycle
// gives quotient and remainder of an unsigned value by a small radix
// depends on abp_pkg
module abp_div #(
    parameter int VALUE_WIDTH = 20,
    parameter int RADIX_W     = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [RADIX_W-1:0]     divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [RADIX_W-1:0]     remainder
);
    import abp_pkg::*;

    localparam int STEPS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W = STEPS * STEP_BITS;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic               run_reg;
    logic               run_next;
    logic               done_reg;
    logic               done_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [PAD_W-1:0]   quo_reg;
    logic [PAD_W-1:0]   quo_next;
    logic [RADIX_W-1:0] rem_reg;
    logic [RADIX_W-1:0] rem_next;

    logic [RADIX_W:0]   part_rem;
    logic [PAD_W-1:0]   part_quo;

    // STEP_BITS restoring steps on a narrow partial remainder
    always_comb
    begin
        part_rem = {1'b0, rem_reg};
        part_quo = quo_reg;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            part_rem = {part_rem[RADIX_W-1:0], part_quo[PAD_W-1]};
            part_quo = {part_quo[PAD_W-2:0], 1'b0};
            if (part_rem >= {1'b0, divisor})
            begin
                part_rem    = part_rem - {1'b0, divisor};
                part_quo[0] = 1'b1;
            end
        end
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(STEPS - 1);
            quo_next = PAD_W'(dividend);
            rem_next = '0;
        end
        else if (run_reg)
        begin
            quo_next = part_quo;
            rem_next = part_rem[RADIX_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg[VALUE_WIDTH-1:0];
    assign remainder = rem_reg;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// testbench: self-checking bench for any_base_palindrome_check_unit, with a scoreboard
// class that predicts each answer and plain tasks that drive numbers and radix writes
// depends on abp_pkg and the checker rtl
module testbench;
    import abp_pkg::*;

    localparam int VALUE_W     = 20;
    localparam int BASE_LIM    = 64;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 100;
    localparam int PHASES      = 9;
    localparam int RANDOM_PER_PHASE = 46;
    localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}};

    class palindrome_scoreboard;
        bit                 expected_answers[$];
        logic [VALUE_W-1:0] pending_numbers[$];
        logic [CFG_W-1:0]   largest_base;
        int                 error_count;

        function new();
            largest_base = RESET_BASE;
            error_count  = 0;
        endfunction

        function int clamped_top(logic [CFG_W-1:0] base_reg);
            int top;
            top = int'(base_reg);
            if (top < SMALLEST_BASE)
                top = SMALLEST_BASE;
            if (top > BASE_LIM)
                top = BASE_LIM;
            return top;
        endfunction

        function bit predict_answer(logic [VALUE_W-1:0] v, logic [CFG_W-1:0] base_reg);
            int top;
            int r;
            int rest;
            int cnt;
            int lo;
            int hi;
            int digs [VALUE_W];
            bit mirror;
            top = clamped_top(base_reg);
            for (r = SMALLEST_BASE; r <= top; r++)
            begin
                rest = int'(v);
                cnt  = 0;
                while (rest != 0)
                begin
                    digs[cnt] = rest % r;
                    rest      = rest / r;
                    cnt++;
                end
                mirror = 1'b1;
                lo = 0;
                hi = cnt - 1;
                while (lo < hi)
                begin
                    if (digs[lo] != digs[hi])
                        mirror = 1'b0;
                    lo++;
                    hi--;
                end
                if (mirror)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_number(logic [VALUE_W-1:0] v);
            expected_answers = {expected_answers, predict_answer(v, largest_base)};
            pending_numbers  = {pending_numbers, v};
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            error_count++;
        endtask

        task check_answer(bit got);
            bit                 want;
            logic [VALUE_W-1:0] v;
            if (expected_answers.size() == 0)
            begin
                report($sformatf("answer %0d with no number pending", got));
            end
            else
            begin
                want = expected_answers.pop_front();
                v    = pending_numbers.pop_front();
                if (got !== want)
                    report($sformatf("number %0d: answer %0d, predicted %0d", v, got, want));
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [VALUE_W-1:0]   number_value;
    logic                 done;
    logic                 is_palindrome_somewhere;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;

    palindrome_scoreboard sb;
    int                   stall_cycles;

    any_base_palindrome_check_unit #(
        .VALUE_WIDTH (VALUE_W),
        .BASE_LIMIT  (BASE_LIM)
    ) dut (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .start                   (start),
        .busy                    (busy),
        .number_value            (number_value),
        .done                    (done),
        .is_palindrome_somewhere (is_palindrome_somewhere),
        .cfg_valid               (cfg_valid),
        .cfg_ready               (cfg_ready),
        .cfg_data                (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_answer(is_palindrome_somewhere);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return 0;
        else if (sel < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // mirrored digit string in the given radix, sized to fit the value width
    function automatic logic [VALUE_W-1:0] make_palindrome(int r);
        int          cnt;
        int          ndig;
        int          i;
        int          rest;
        int          digs [VALUE_W];
        logic [63:0] acc;
        rest = int'(VALUE_MASK);
        cnt  = 0;
        while (rest != 0)
        begin
            rest = rest / r;
            cnt++;
        end
        ndig = $urandom_range(1, cnt - 1);
        for (i = 0; i < (ndig + 1) / 2; i++)
        begin
            digs[i] = (i == 0) ? $urandom_range(1, r - 1) : $urandom_range(0, r - 1);
            digs[ndig - 1 - i] = digs[i];
        end
        acc = 0;
        for (i = 0; i < ndig; i++)
            acc = acc * 64'(r) + 64'(digs[i]);
        return acc[VALUE_W-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] pick_number(int top);
        int sel;
        int r;
        sel = $urandom_range(0, 99);
        if (sel < 45)
        begin
            if ($urandom_range(0, 9) == 0)
                r = $urandom_range(SMALLEST_BASE, BASE_LIM);
            else
                r = $urandom_range(SMALLEST_BASE, top);
            return make_palindrome(r);
        end
        else if (sel < 65)
            return VALUE_W'($urandom_range(0, 300));
        else
            return VALUE_W'($urandom());
    endfunction

    task automatic send_number(input logic [VALUE_W-1:0] v, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start        <= 1'b1;
        number_value <= v;
        do @(posedge clk); while (busy);
        sb.note_number(v);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_largest_base(input logic [CFG_W-1:0] b);
        wait_drained();
        repeat (10) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= b;
        do @(posedge clk); while (!cfg_ready);
        sb.largest_base = b;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [VALUE_W-1:0] directed [20];
        logic [CFG_W-1:0]   phase_base [PHASES];
        int                 p;
        int                 i;
        int                 top;
        bit                 steady;

        directed = '{20'd0, 20'd1, 20'd2, 20'd3, 20'd4, 20'd5, 20'd6, 20'd9, 20'd10,
                     20'hFFFFF, 20'h80000, 20'hAAAAA, 20'h55555, 20'h7FFFF, 20'h10000,
                     20'd63, 20'd64, 20'd65, 20'd4095, 20'd4096};
        phase_base = '{RESET_BASE, 7'd2, 7'd0, 7'd127, 7'd1, 7'd65, 7'd3,
                       7'($urandom_range(4, 63)), 7'd64};

        sb           = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        number_value = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (p = 0; p < PHASES; p++)
        begin
            if (p > 0)
                write_largest_base(phase_base[p]);
            top    = sb.clamped_top(sb.largest_base);
            steady = (p == 3 || p == 6);
            if (p == 0)
            begin
                foreach (directed[i])
                    send_number(directed[i], pick_gap());
            end
            else
            begin
                send_number(20'd2, pick_gap());
                send_number(20'd6, pick_gap());
                send_number(20'hFFFFF, pick_gap());
            end
            for (i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                if ((p == 1 && i == 25) || $urandom_range(0, 99) < 3)
                    wait_drained();
                send_number(pick_number(top), steady ? 0 : pick_gap());
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== any_base_palindrome_check_unit.f =====
hdl/abp_pkg.sv
hdl/abp_div.sv
hdl/any_base_palindrome_check_unit.sv
bench/testbench.sv
